// ===== hw/rtl/bcd_time_frame_decoder_unit_macros.svh =====
// Assertion macros used by the time frame decoder checker.
`ifndef BCD_TIME_FRAME_DECODER_UNIT_MACROS_SVH
`define BCD_TIME_FRAME_DECODER_UNIT_MACROS_SVH

// Consequent checked in the same cycle.
`define BTFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btfd check failed");

// Consequent checked in the cycle after the antecedent.
`define BTFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btfd check failed");

`endif

// ===== hw/rtl/btfd_pkg.sv =====
// Types, constants and helper functions of the BCD time frame decoder.
package btfd_pkg;

    localparam int BTFD_CENTURY_TRIES = 4;
    localparam int BTFD_BASE_YEAR     = 1900;

    localparam int Y_W     = 12;
    localparam int Q100_W  = 6;
    localparam int Q7_W    = 10;
    localparam int RCP_W   = 14;
    localparam int MUL_W   = Y_W + RCP_W;
    localparam int SH100   = 19;
    localparam int SH7     = 16;

    localparam logic [RCP_W-1:0] RECIP100 = 14'd5243;
    localparam logic [RCP_W-1:0] RECIP7   = 14'd9363;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_MONTH  = 2'd1;
    localparam logic [1:0] STAT_NO_CENTURY = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_YEAR   = 8'b0000_0010,
        ST_DIV100 = 8'b0000_0100,
        ST_SUM    = 8'b0000_1000,
        ST_DIV7   = 8'b0001_0000,
        ST_CHECK  = 8'b0010_0000,
        ST_YDAY   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [5:0] hours;
        logic       summer;
        logic [5:0] mday;
        logic [2:0] wday;
        logic [4:0] month;
        logic [7:0] year;
    } t_fields;

    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] t;
        t = {4'b0, b[7:4]};
        return (t << 3) + (t << 1) + {4'b0, b[3:0]};
    endfunction

    function automatic logic [2:0] wd_offset(input logic [3:0] idx);
        case (idx)
            4'd0:    return 3'd0;
            4'd1:    return 3'd3;
            4'd2:    return 3'd2;
            4'd3:    return 3'd5;
            4'd4:    return 3'd0;
            4'd5:    return 3'd3;
            4'd6:    return 3'd5;
            4'd7:    return 3'd1;
            4'd8:    return 3'd4;
            4'd9:    return 3'd6;
            4'd10:   return 3'd2;
            4'd11:   return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    // Days in the months before month idx, common year.
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        case (idx)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd59;
            4'd3:    return 9'd90;
            4'd4:    return 9'd120;
            4'd5:    return 9'd151;
            4'd6:    return 9'd181;
            4'd7:    return 9'd212;
            4'd8:    return 9'd243;
            4'd9:    return 9'd273;
            4'd10:   return 9'd304;
            4'd11:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/btfd_decode.sv =====
// BCD field decode of one six-byte time frame.
module btfd_decode import btfd_pkg::*; (
    input  logic [7:0] i_sec_byte,
    input  logic [7:0] i_min_byte,
    input  logic [7:0] i_hour_byte,
    input  logic [7:0] i_mday_byte,
    input  logic [7:0] i_wday_month_byte,
    input  logic [7:0] i_year_byte,
    output t_fields    o_fields
);

    logic [7:0] sec_v;
    logic [7:0] min_v;
    logic [7:0] hour_v;
    logic [7:0] mday_v;
    logic [7:0] month_v;

    always_comb begin
        sec_v   = bcd_val({1'b0, i_sec_byte[6:0]});
        min_v   = bcd_val({1'b0, i_min_byte[6:0]});
        hour_v  = bcd_val({2'b0, i_hour_byte[5:0]});
        mday_v  = bcd_val({2'b0, i_mday_byte[5:0]});
        month_v = bcd_val({3'b0, i_wday_month_byte[7:3]});

        o_fields.seconds = sec_v[6:0];
        o_fields.minutes = min_v[6:0];
        o_fields.hours   = hour_v[5:0];
        o_fields.summer  = i_hour_byte[6];
        o_fields.mday    = mday_v[5:0];
        o_fields.wday    = (i_wday_month_byte[2:0] == 3'd7) ? 3'd0 : i_wday_month_byte[2:0];
        o_fields.month   = month_v[4:0];
        o_fields.year    = bcd_val(i_year_byte);
    end

endmodule

// ===== hw/rtl/bcd_time_frame_decoder_unit.sv =====
// Top level of the BCD radio clock time frame decoder.
//
// Input channel: six frame bytes with i_in_valid / o_in_stall. A beat is
// taken when i_in_valid is high and o_in_stall is low; o_in_stall stays
// high from acceptance until the result beat has been taken.
// Output channel: decoded time fields with o_out_valid / i_out_stall. The
// result is held in registers and stays put while i_out_stall is high.
// Sequence: a frame with a bad month shows its result in the cycle after
// acceptance. Otherwise each century trial steps through year, /100, sum,
// /7 and compare on the shared reciprocal multiplier, and a day-of-year
// pass (year, /100, day of year) follows before the result shows; from 1
// to CENTURY_TRIES trials are made. One frame is in flight at a time; the
// next beat can be taken only after the result has been taken and the
// sequencer is back in idle.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid; a pending result is discarded.
module bcd_time_frame_decoder_unit import btfd_pkg::*; #(
    parameter int CENTURY_TRIES = BTFD_CENTURY_TRIES,
    parameter int BASE_YEAR     = BTFD_BASE_YEAR
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_sec_byte,
    input  logic [7:0] i_min_byte,
    input  logic [7:0] i_hour_byte,
    input  logic [7:0] i_mday_byte,
    input  logic [7:0] i_wday_month_byte,
    input  logic [7:0] i_year_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_seconds,
    output logic [6:0] o_minutes,
    output logic [5:0] o_hours,
    output logic       o_summer_time,
    output logic [5:0] o_month_day,
    output logic [2:0] o_week_day,
    output logic [3:0] o_month_index,
    output logic [8:0] o_years_since_base,
    output logic [8:0] o_year_day,
    output logic [1:0] o_status
);

    localparam int TRY_W = (CENTURY_TRIES > 1) ? $clog2(CENTURY_TRIES) : 1;

    t_fields dec;

    t_state            r_state, n_state;
    logic [TRY_W-1:0]  r_try, n_try;
    logic              r_final, n_final;
    logic [6:0]        r_sec, n_sec;
    logic [6:0]        r_min, n_min;
    logic [5:0]        r_hours, n_hours;
    logic              r_summer, n_summer;
    logic [5:0]        r_mday, n_mday;
    logic [2:0]        r_wday, n_wday;
    logic [3:0]        r_mon_idx, n_mon_idx;
    logic [7:0]        r_year, n_year;
    logic [8:0]        r_ysb, n_ysb;
    logic [8:0]        r_yday, n_yday;
    logic [1:0]        r_status, n_status;
    logic [Y_W-1:0]    r_y, n_y;
    logic [Q100_W-1:0] r_q100, n_q100;
    logic [Y_W-1:0]    r_sum, n_sum;
    logic [Q7_W-1:0]   r_q7, n_q7;

    logic [Y_W-1:0]    mul_a;
    logic [RCP_W-1:0]  mul_b;
    logic [MUL_W-1:0]  prod;
    logic [8:0]        cand;
    logic              early;
    logic [Y_W-1:0]    rem7;
    logic              hundred;
    logic              leap;
    logic [8:0]        acc;

    btfd_decode u_decode (
        .i_sec_byte        (i_sec_byte),
        .i_min_byte        (i_min_byte),
        .i_hour_byte       (i_hour_byte),
        .i_mday_byte       (i_mday_byte),
        .i_wday_month_byte (i_wday_month_byte),
        .i_year_byte       (i_year_byte),
        .o_fields          (dec)
    );

    // Shared reciprocal multiplier: /100 of the year, /7 of the weekday sum.
    always_comb begin
        if (r_state == ST_DIV100) begin
            mul_a = r_y;
            mul_b = RECIP100;
        end else begin
            mul_a = r_sum;
            mul_b = RECIP7;
        end
        prod = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_comb begin
        cand    = 9'(r_year) + 9'(r_try) * 9'd100;
        early   = (r_mon_idx < 4'd2);
        rem7    = r_sum - Y_W'(r_q7) * Y_W'(7);
        hundred = (r_y == Y_W'(r_q100) * Y_W'(100));
        leap    = (r_y[1:0] == 2'd0) && (!hundred || (r_q100[1:0] == 2'd0));
        acc     = cum_days(r_mon_idx) + 9'(leap && (r_mon_idx >= 4'd2)) + 9'(r_mday);
    end

    always_comb begin
        n_state   = r_state;
        n_try     = r_try;
        n_final   = r_final;
        n_sec     = r_sec;
        n_min     = r_min;
        n_hours   = r_hours;
        n_summer  = r_summer;
        n_mday    = r_mday;
        n_wday    = r_wday;
        n_mon_idx = r_mon_idx;
        n_year    = r_year;
        n_ysb     = r_ysb;
        n_yday    = r_yday;
        n_status  = r_status;
        n_y       = r_y;
        n_q100    = r_q100;
        n_sum     = r_sum;
        n_q7      = r_q7;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sec    = dec.seconds;
                    n_min    = dec.minutes;
                    n_hours  = dec.hours;
                    n_summer = dec.summer;
                    n_mday   = dec.mday;
                    n_wday   = dec.wday;
                    n_year   = dec.year;
                    n_ysb    = 9'(dec.year);
                    n_try    = '0;
                    n_final  = 1'b0;
                    if (dec.month == 5'd0 || dec.month > 5'd12) begin
                        n_mon_idx = 4'd0;
                        n_yday    = 9'd0;
                        n_status  = STAT_BAD_MONTH;
                        n_state   = ST_DONE;
                    end else begin
                        n_mon_idx = 4'(dec.month - 5'd1);
                        n_status  = STAT_OK;
                        n_state   = ST_YEAR;
                    end
                end
            end
            ST_YEAR: begin
                if (r_final) begin
                    n_y = Y_W'(BASE_YEAR) + Y_W'(r_ysb);
                end else begin
                    n_y = Y_W'(BASE_YEAR) + Y_W'(cand) - Y_W'(early);
                end
                n_state = ST_DIV100;
            end
            ST_DIV100: begin
                n_q100  = prod[SH100 +: Q100_W];
                n_state = r_final ? ST_YDAY : ST_SUM;
            end
            ST_SUM: begin
                n_sum = r_y + {2'b0, r_y[Y_W-1:2]} - Y_W'(r_q100)
                      + Y_W'(r_q100[Q100_W-1:2]) + Y_W'(wd_offset(r_mon_idx))
                      + Y_W'(r_mday);
                n_state = ST_DIV7;
            end
            ST_DIV7: begin
                n_q7    = prod[SH7 +: Q7_W];
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = ST_YEAR;
                if (rem7[2:0] == r_wday) begin
                    n_ysb   = cand;
                    n_final = 1'b1;
                end else if (r_try == TRY_W'(CENTURY_TRIES - 1)) begin
                    n_ysb    = 9'(r_year);
                    n_status = STAT_NO_CENTURY;
                    n_final  = 1'b1;
                end else begin
                    n_try = r_try + TRY_W'(1);
                end
            end
            ST_YDAY: begin
                n_yday  = (acc == 9'd0) ? 9'd0 : acc - 9'd1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_try     <= n_try;
        r_final   <= n_final;
        r_sec     <= n_sec;
        r_min     <= n_min;
        r_hours   <= n_hours;
        r_summer  <= n_summer;
        r_mday    <= n_mday;
        r_wday    <= n_wday;
        r_mon_idx <= n_mon_idx;
        r_year    <= n_year;
        r_ysb     <= n_ysb;
        r_yday    <= n_yday;
        r_status  <= n_status;
        r_y       <= n_y;
        r_q100    <= n_q100;
        r_sum     <= n_sum;
        r_q7      <= n_q7;
    end

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = (r_state == ST_DONE);
    assign o_seconds          = r_sec;
    assign o_minutes          = r_min;
    assign o_hours            = r_hours;
    assign o_summer_time      = r_summer;
    assign o_month_day        = r_mday;
    assign o_week_day         = r_wday;
    assign o_month_index      = r_mon_idx;
    assign o_years_since_base = r_ysb;
    assign o_year_day         = r_yday;
    assign o_status           = r_status;

endmodule

// ===== hw/rtl/btfd_checker.sv =====
// Port-level checker for the time frame decoder, bound to the top level.
`include "bcd_time_frame_decoder_unit_macros.svh"

module btfd_checker import btfd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_month_index,
    input logic [8:0] o_year_day,
    input logic [1:0] o_status
);

    logic bad_month_shown;
    logic bad_month_clear;
    logic status_known;

    assign bad_month_shown = o_out_valid && (o_status == STAT_BAD_MONTH);
    assign bad_month_clear = (o_month_index == 4'd0) && (o_year_day == 9'd0);
    assign status_known    = (o_status == STAT_OK) || (o_status == STAT_BAD_MONTH)
                          || (o_status == STAT_NO_CENTURY);

    `BTFD_ASSERT_NEXT(a_busy_after_beat, i_in_valid && !o_in_stall, o_in_stall)
    `BTFD_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall, o_out_valid)
    `BTFD_ASSERT_NOW(a_no_beat_with_result, o_out_valid, o_in_stall)
    `BTFD_ASSERT_NOW(a_bad_month_zeroed, bad_month_shown, bad_month_clear)
    `BTFD_ASSERT_NOW(a_status_known, o_out_valid, status_known)

endmodule

bind bcd_time_frame_decoder_unit btfd_checker u_btfd_checker (.*);
